// ===== rtl/eas_pkg.sv =====
// Shared types and constants of the exhaustive assignment solver.
package eas_pkg;

  localparam int IDX_W   = 3;
  localparam int TOT_W   = 19;
  localparam int CFG_W   = 4;
  localparam int CVAL_W  = 16;
  localparam logic [TOT_W-1:0] TOTAL_MAX = 19'h7FFFF;

  // Request codes
  localparam logic REQ_LOAD  = 1'b0;
  localparam logic REQ_SOLVE = 1'b1;

  typedef logic [IDX_W-1:0] idx_t;

  typedef struct packed {
    logic              req_type;
    logic [IDX_W-1:0]  row_index;
    logic [IDX_W-1:0]  column_index;
    logic [CVAL_W-1:0] cost_value;
  } req_t;

  typedef struct packed {
    logic [IDX_W-1:0] track_number;
    logic [IDX_W-1:0] assigned_detection;
    logic [TOT_W-1:0] best_total;
    logic             last;
  } res_t;

endpackage

// ===== rtl/eas_cost_mem.sv =====
// Cost matrix memory: one write port, one registered read port.
module eas_cost_mem #(
  parameter int DEPTH  = 64,
  parameter int AW     = 6,
  parameter int DATA_W = 16
) (
  input  logic              clk_i,
  input  logic              we_i,
  input  logic [AW-1:0]     waddr_i,
  input  logic [DATA_W-1:0] wdata_i,
  input  logic [AW-1:0]     raddr_i,
  output logic [DATA_W-1:0] rdata_o
);

  logic [DATA_W-1:0] mem_q [DEPTH];
  logic [DATA_W-1:0] rdata_q;

  // Write one entry, read one entry a cycle
  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_q <= mem_q[raddr_i];
  end

  assign rdata_o = rdata_q;

endmodule

// ===== rtl/eas_perm_next.sv =====
// Next lexicographic order of the first n entries; wraps to identity.
module eas_perm_next
  import eas_pkg::*;
#(
  parameter int CAP = 8,
  parameter int KW  = 3
) (
  input  idx_t             order_i [CAP],
  input  logic [CFG_W-1:0] n_i,
  output idx_t             next_o  [CAP],
  output logic             wrap_o
);

  logic          found;
  logic [KW-1:0] p;
  logic [KW-1:0] j;
  logic [CFG_W-1:0] s;

  // Find pivot, its successor, then swap and reverse the suffix
  always_comb begin
    found = 1'b0;
    p     = '0;
    j     = '0;
    s     = '0;
    for (int i = 1; i < CAP; i++) begin
      if (i < int'(n_i) && order_i[i-1] < order_i[i]) begin
        found = 1'b1;
        p     = KW'(i - 1);
      end
    end
    for (int m = 0; m < CAP; m++) begin
      if (m < int'(n_i) && m > int'(p) && order_i[m] > order_i[p]) begin
        j = KW'(m);
      end
    end
    for (int k = 0; k < CAP; k++) begin
      next_o[k] = order_i[k];
      if (!found) begin
        next_o[k] = IDX_W'(k);
      end else if (k == int'(p)) begin
        next_o[k] = order_i[j];
      end else if (k > int'(p) && k < int'(n_i)) begin
        s = CFG_W'(int'(n_i) + int'(p) - k);
        if (KW'(s) == j) begin
          next_o[k] = order_i[p];
        end else begin
          next_o[k] = order_i[KW'(s)];
        end
      end
    end
    wrap_o = !found;
  end

endmodule

// ===== rtl/exhaustive_assignment_solver_core.sv =====
// Top level: exhaustive assignment solver over a cost matrix memory.
// A load word writes one cost entry. A solve enumerates every order of the first n columns
// (one cost memory read per cycle, n reads per order), drains the last read and emits
// n result words; the single memory read port sets the read rate.
// Reset: track_count is 8, the order is identity, no result is pending.
// The cost memory is not cleared; the user must write entries before they are read (not enforced).
module exhaustive_assignment_solver_core
  import eas_pkg::*;
#(
  parameter int MAX_TRACKS = 8,
  parameter int COST_BITS  = 16
) (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             in_valid_i,
  output logic             in_stall_o,
  input  req_t             in_word_i,
  output logic             out_valid_o,
  input  logic             out_stall_i,
  output res_t             out_word_o,
  input  logic             cfg_valid_i,
  output logic             cfg_ready_o,
  input  logic [CFG_W-1:0] cfg_data_i
);

  localparam int CAP   = (MAX_TRACKS < 8) ? MAX_TRACKS : 8;
  localparam int KW    = (CAP > 1) ? $clog2(CAP) : 1;
  localparam int DEPTH = MAX_TRACKS * MAX_TRACKS;
  localparam int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int SUM_W = COST_BITS + 3;
  localparam int TW    = (SUM_W > TOT_W) ? SUM_W : TOT_W;

  typedef enum logic [3:0] {
    ST_IDLE  = 4'b0001,
    ST_SUM   = 4'b0010,
    ST_DRAIN = 4'b0100,
    ST_EMIT  = 4'b1000
  } state_e;

  state_e state_q, state_d;
  logic [CFG_W-1:0] tc_q;
  logic [CFG_W-1:0] n_q, n_d;
  logic [KW-1:0]    k_q, k_d;
  idx_t             order_q [CAP];
  idx_t             order_d [CAP];
  idx_t             prev_q  [CAP];
  idx_t             bord_q  [CAP];
  idx_t             next_ord [CAP];
  logic             wrap;
  logic [SUM_W-1:0] acc_q, best_q;
  logic             have_q;
  logic             rd_v_q, rd_last_q;
  logic             issue, issue_last;
  logic [AW-1:0]    raddr, waddr;
  logic [COST_BITS-1:0] rdata;
  logic             we;
  logic [SUM_W-1:0] tot;
  logic             better;
  logic             in_acc, out_ld, emit_last;
  logic             out_valid_q;
  res_t             out_word_q;
  logic [CFG_W-1:0] nsz;
  logic [TW-1:0]    best_ext;

  assign cfg_ready_o = 1'b1;
  assign in_stall_o  = (state_q != ST_IDLE);
  assign in_acc      = in_valid_i && !in_stall_o;

  // Clamp the configured matrix size
  always_comb begin
    if (tc_q == '0) begin
      nsz = CFG_W'(1);
    end else if (int'(tc_q) > CAP) begin
      nsz = CFG_W'(CAP);
    end else begin
      nsz = tc_q;
    end
  end

  // Load path into the cost memory
  assign we = in_acc && (in_word_i.req_type == REQ_LOAD) &&
              (int'(in_word_i.row_index) < MAX_TRACKS) &&
              (int'(in_word_i.column_index) < MAX_TRACKS);
  assign waddr = AW'(AW'(in_word_i.row_index) * AW'(MAX_TRACKS) +
                     AW'(in_word_i.column_index));

  // Read path: row k at its current column
  assign issue      = (state_q == ST_SUM);
  assign issue_last = issue && (CFG_W'(k_q) == n_q - CFG_W'(1));
  assign raddr      = AW'(AW'(k_q) * AW'(MAX_TRACKS) + AW'(order_q[k_q]));

  eas_cost_mem #(
    .DEPTH  (DEPTH),
    .AW     (AW),
    .DATA_W (COST_BITS)
  ) u_mem (
    .clk_i   (clk_i),
    .we_i    (we),
    .waddr_i (waddr),
    .wdata_i (COST_BITS'(in_word_i.cost_value)),
    .raddr_i (raddr),
    .rdata_o (rdata)
  );

  eas_perm_next #(
    .CAP (CAP),
    .KW  (KW)
  ) u_next (
    .order_i (order_q),
    .n_i     (n_q),
    .next_o  (next_ord),
    .wrap_o  (wrap)
  );

  // Accumulate and compare against the best total
  assign tot    = acc_q + SUM_W'(rdata);
  assign better = rd_v_q && rd_last_q && (!have_q || tot < best_q);

  assign emit_last = (CFG_W'(k_q) == n_q - CFG_W'(1));
  assign out_ld    = (state_q == ST_EMIT) && (!out_valid_q || !out_stall_i);
  assign best_ext  = TW'(best_q);

  // Sequencer next state
  always_comb begin
    state_d = state_q;
    n_d     = n_q;
    k_d     = k_q;
    order_d = order_q;
    unique case (state_q)
      ST_IDLE: begin
        if (in_acc && in_word_i.req_type == REQ_SOLVE) begin
          state_d = ST_SUM;
          n_d     = nsz;
          k_d     = '0;
        end
      end
      ST_SUM: begin
        if (issue_last) begin
          k_d     = '0;
          order_d = next_ord;
          if (wrap) begin
            state_d = ST_DRAIN;
          end
        end else begin
          k_d = k_q + KW'(1);
        end
      end
      ST_DRAIN: begin
        if (rd_v_q && rd_last_q) begin
          state_d = ST_EMIT;
          k_d     = '0;
        end
      end
      ST_EMIT: begin
        if (out_ld) begin
          if (emit_last) begin
            state_d = ST_IDLE;
          end else begin
            k_d = k_q + KW'(1);
          end
        end
      end
      default: state_d = ST_IDLE;
    endcase
  end

  // Control registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      tc_q        <= CFG_W'(8);
      n_q         <= CFG_W'(1);
      k_q         <= '0;
      rd_v_q      <= 1'b0;
      rd_last_q   <= 1'b0;
      have_q      <= 1'b0;
      out_valid_q <= 1'b0;
      for (int i = 0; i < CAP; i++) begin
        order_q[i] <= IDX_W'(i);
      end
    end else begin
      state_q   <= state_d;
      n_q       <= n_d;
      k_q       <= k_d;
      order_q   <= order_d;
      rd_v_q    <= issue;
      rd_last_q <= issue_last;
      if (cfg_valid_i && cfg_ready_o) begin
        tc_q <= cfg_data_i;
      end
      if (state_q == ST_IDLE) begin
        have_q <= 1'b0;
      end else if (better) begin
        have_q <= 1'b1;
      end
      if (out_ld) begin
        out_valid_q <= 1'b1;
      end else if (!out_stall_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  // Datapath registers
  always_ff @(posedge clk_i) begin
    if (state_q == ST_IDLE) begin
      acc_q <= '0;
    end else if (rd_v_q) begin
      acc_q <= rd_last_q ? '0 : tot;
    end
    if (issue_last) begin
      prev_q <= order_q;
    end
    if (better) begin
      best_q <= tot;
      bord_q <= prev_q;
    end
    if (out_ld) begin
      out_word_q.track_number       <= IDX_W'(k_q);
      out_word_q.assigned_detection <= bord_q[k_q];
      out_word_q.best_total         <= (best_ext > TW'(TOTAL_MAX)) ? TOTAL_MAX
                                                                   : TOT_W'(best_ext);
      out_word_q.last               <= emit_last;
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_word_o  = out_word_q;

endmodule
